@@ design/adhc_pkg.sv @@
// ----------------------------------------------------------------------------
// adhc_pkg
// Shared types, constants and lookup tables for the AC-3 / E-AC-3 / DTS
// sync header classifier.
// ----------------------------------------------------------------------------
package adhc_pkg;

  // Ten-byte candidate window, byte 0 in the lowest bits
  typedef logic [9:0][7:0] window_t;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_AC3      = 3'd1,
    KIND_EAC3     = 3'd2,
    KIND_DTS_512  = 3'd3,
    KIND_DTS_1024 = 3'd4,
    KIND_DTS_2048 = 3'd5
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [14:0] frame_bytes;
    logic [17:0] sample_rate;
    logic [2:0]  repeat_count;
    logic        little_endian;
  } hdr_res_t;

  localparam logic [7:0]  AC3_SYNC0     = 8'h0B;
  localparam logic [7:0]  AC3_SYNC1     = 8'h77;
  localparam logic [4:0]  BSID_AC3_MAX  = 5'd10;
  localparam logic [4:0]  BSID_MAX      = 5'd17;
  localparam logic [5:0]  FRMSIZE_MAX   = 6'd37;
  localparam logic [1:0]  FSCOD_RSVD    = 2'd3;
  localparam logic [1:0]  STRMTYP_RSVD  = 2'd3;

  localparam logic [31:0] DTS14_BE_SYNC = 32'h1FFFE800;
  localparam logic [31:0] DTS14_LE_SYNC = 32'hFF1F00E8;
  localparam logic [31:0] DTS16_BE_SYNC = 32'h7FFE8001;
  localparam logic [31:0] DTS16_LE_SYNC = 32'hFE7F0180;
  localparam logic [7:0]  DTS14_EXT_HI  = 8'h07;
  localparam logic [7:0]  DTS14_EXT_LO  = 8'hF0;
  localparam logic [7:0]  DTS_TERM_MASK = 8'h7C;
  localparam logic [14:0] DTS_FSZ_MIN   = 15'd96;
  localparam logic [14:0] DTS_FSZ_MAX   = 15'd16384;
  localparam logic [6:0]  DTS_BLK_512   = 7'd15;
  localparam logic [6:0]  DTS_BLK_1024  = 7'd31;
  localparam logic [6:0]  DTS_BLK_2048  = 7'd63;

  // AC-3 bit rate in kbit/s by frame-size code / 2
  function automatic logic [9:0] ac3_kbps(input logic [4:0] idx);
    logic [9:0] r;
    unique case (idx)
      5'd0:    r = 10'd32;
      5'd1:    r = 10'd40;
      5'd2:    r = 10'd48;
      5'd3:    r = 10'd56;
      5'd4:    r = 10'd64;
      5'd5:    r = 10'd80;
      5'd6:    r = 10'd96;
      5'd7:    r = 10'd112;
      5'd8:    r = 10'd128;
      5'd9:    r = 10'd160;
      5'd10:   r = 10'd192;
      5'd11:   r = 10'd224;
      5'd12:   r = 10'd256;
      5'd13:   r = 10'd320;
      5'd14:   r = 10'd384;
      5'd15:   r = 10'd448;
      5'd16:   r = 10'd512;
      5'd17:   r = 10'd576;
      5'd18:   r = 10'd640;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // floor(320 * kbps / 147): 16-bit words per frame at 44.1 kHz, before padding
  function automatic logic [10:0] ac3_words_44k(input logic [4:0] idx);
    logic [10:0] w;
    unique case (idx)
      5'd0:    w = 11'd69;
      5'd1:    w = 11'd87;
      5'd2:    w = 11'd104;
      5'd3:    w = 11'd121;
      5'd4:    w = 11'd139;
      5'd5:    w = 11'd174;
      5'd6:    w = 11'd208;
      5'd7:    w = 11'd243;
      5'd8:    w = 11'd278;
      5'd9:    w = 11'd348;
      5'd10:   w = 11'd417;
      5'd11:   w = 11'd487;
      5'd12:   w = 11'd557;
      5'd13:   w = 11'd696;
      5'd14:   w = 11'd835;
      5'd15:   w = 11'd975;
      5'd16:   w = 11'd1114;
      5'd17:   w = 11'd1253;
      5'd18:   w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  function automatic logic [17:0] ac3_rate(input logic [1:0] code);
    logic [17:0] r;
    unique case (code)
      2'd0:    r = 18'd48000;
      2'd1:    r = 18'd44100;
      2'd2:    r = 18'd32000;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] dts_rate(input logic [3:0] code);
    logic [17:0] r;
    unique case (code)
      4'd1:    r = 18'd8000;
      4'd2:    r = 18'd16000;
      4'd3:    r = 18'd32000;
      4'd4:    r = 18'd64000;
      4'd5:    r = 18'd128000;
      4'd6:    r = 18'd11025;
      4'd7:    r = 18'd22050;
      4'd8:    r = 18'd44100;
      4'd9:    r = 18'd88200;
      4'd10:   r = 18'd176400;
      4'd11:   r = 18'd12000;
      4'd12:   r = 18'd24000;
      4'd13:   r = 18'd48000;
      4'd14:   r = 18'd96000;
      4'd15:   r = 18'd192000;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/adhc_ac3_parse.sv @@
// ----------------------------------------------------------------------------
// adhc_ac3_parse
// Combinational AC-3 / E-AC-3 sync header decode of one window.
// ----------------------------------------------------------------------------
module adhc_ac3_parse import adhc_pkg::*; (
  input  window_t  win_i,
  output hdr_res_t res_o
);

  logic        sync;
  logic [4:0]  bsid;
  logic [1:0]  fscod;
  logic [5:0]  frmsizecod;
  logic [1:0]  numblk_cod;
  logic [9:0]  kbps;
  logic [10:0] words_44k;
  logic [11:0] ac3_words;
  logic [11:0] eac3_words;
  logic [17:0] fs_rate;
  logic [17:0] cod_rate;
  logic        ac3_ok;
  logic        eac3_ok;

  assign sync       = (win_i[0] == AC3_SYNC0) && (win_i[1] == AC3_SYNC1);
  assign bsid       = win_i[5][7:3];
  assign fscod      = win_i[4][7:6];
  assign frmsizecod = win_i[4][5:0];
  assign numblk_cod = win_i[4][5:4];
  assign kbps       = ac3_kbps(frmsizecod[5:1]);
  assign words_44k  = ac3_words_44k(frmsizecod[5:1]);
  assign fs_rate    = ac3_rate(fscod);
  assign cod_rate   = ac3_rate(numblk_cod);

  always_comb begin
    unique case (fscod)
      2'd0:    ac3_words = {1'b0, kbps, 1'b0};
      2'd1:    ac3_words = {1'b0, words_44k + 11'(frmsizecod[0])};
      2'd2:    ac3_words = {kbps, 2'b00};
      default: ac3_words = '0;
    endcase
  end

  assign eac3_words = {1'b0, win_i[2][2:0], win_i[3]} + 12'd1;

  assign ac3_ok  = sync && (bsid <= BSID_AC3_MAX) && (fscod != FSCOD_RSVD) &&
                   (frmsizecod <= FRMSIZE_MAX);
  assign eac3_ok = sync && (bsid > BSID_AC3_MAX) && (bsid <= BSID_MAX) &&
                   (win_i[2][7:6] != STRMTYP_RSVD) &&
                   !((fscod == FSCOD_RSVD) && (numblk_cod == FSCOD_RSVD));

  always_comb begin
    res_o = '0;
    if (ac3_ok) begin
      res_o.valid        = 1'b1;
      res_o.kind         = KIND_AC3;
      res_o.frame_bytes  = {2'b00, ac3_words, 1'b0};
      res_o.sample_rate  = fs_rate;
      res_o.repeat_count = 3'd1;
    end else if (eac3_ok) begin
      res_o.valid       = 1'b1;
      res_o.kind        = KIND_EAC3;
      res_o.frame_bytes = {2'b00, eac3_words, 1'b0};
      // reported rate is four times the coded rate
      if (fscod == FSCOD_RSVD) begin
        // reduced-rate code, half rate, always six blocks
        res_o.sample_rate  = {cod_rate[16:0], 1'b0};
        res_o.repeat_count = 3'd1;
      end else begin
        res_o.sample_rate = {fs_rate[15:0], 2'b00};
        unique case (numblk_cod)
          2'd0:    res_o.repeat_count = 3'd6;
          2'd1:    res_o.repeat_count = 3'd3;
          2'd2:    res_o.repeat_count = 3'd2;
          default: res_o.repeat_count = 3'd1;
        endcase
      end
    end
  end

endmodule

@@ design/adhc_dts_parse.sv @@
// ----------------------------------------------------------------------------
// adhc_dts_parse
// Combinational DTS core sync header decode of one window: 14/16-bit
// packing, either byte order.
// ----------------------------------------------------------------------------
module adhc_dts_parse import adhc_pkg::*; (
  input  window_t  win_i,
  output hdr_res_t res_o
);

  logic [31:0] preamble;
  logic        hit;
  logic [6:0]  blk;
  logic [3:0]  sr;
  logic        le;
  logic [7:0]  hdr_byte;
  logic [13:0] fsz_field;
  logic [14:0] fsz;
  logic        term_ok;
  logic        size_ok;
  kind_e       kind;

  assign preamble = {win_i[0], win_i[1], win_i[2], win_i[3]};

  always_comb begin
    hit = 1'b1;
    blk = '0;
    sr  = '0;
    le  = 1'b0;
    priority if (preamble == DTS14_BE_SYNC) begin
      hit = (win_i[4] == DTS14_EXT_HI) && (win_i[5] == DTS14_EXT_LO);
      blk = {win_i[5][2:0], win_i[6][5:2]};
      sr  = win_i[8][5:2];
    end else if (preamble == DTS14_LE_SYNC) begin
      hit = (win_i[5] == DTS14_EXT_HI) && (win_i[4] == DTS14_EXT_LO);
      blk = {win_i[4][2:0], win_i[7][5:2]};
      sr  = win_i[9][5:2];
      le  = 1'b1;
    end else if (preamble == DTS16_BE_SYNC) begin
      blk = {1'b0, win_i[5][7:2]};
      sr  = win_i[8][5:2];
    end else if (preamble == DTS16_LE_SYNC) begin
      blk = {1'b0, win_i[4][7:2]};
      sr  = win_i[9][5:2];
      le  = 1'b1;
    end else begin
      hit = 1'b0;
    end
  end

  assign hdr_byte  = le ? win_i[5] : win_i[4];
  assign fsz_field = le ? {win_i[4][1:0], win_i[7], win_i[6][7:4]}
                        : {win_i[5][1:0], win_i[6], win_i[7][7:4]};
  assign fsz       = {1'b0, fsz_field} + 15'd1;

  // normal frame: the five bits after the frame-type bit must all be set
  assign term_ok = !hdr_byte[7] || ((hdr_byte & DTS_TERM_MASK) == DTS_TERM_MASK);
  assign size_ok = (fsz >= DTS_FSZ_MIN) && (fsz <= DTS_FSZ_MAX);

  always_comb begin
    priority if (blk == DTS_BLK_512)  kind = KIND_DTS_512;
    else if (blk == DTS_BLK_1024)     kind = KIND_DTS_1024;
    else if (blk == DTS_BLK_2048)     kind = KIND_DTS_2048;
    else                              kind = KIND_NONE;
  end

  always_comb begin
    res_o = '0;
    if (hit && (sr != 4'd0) && term_ok && size_ok && (kind != KIND_NONE)) begin
      res_o.valid         = 1'b1;
      res_o.kind          = kind;
      res_o.frame_bytes   = fsz;
      res_o.sample_rate   = dts_rate(sr);
      res_o.repeat_count  = 3'd1;
      res_o.little_endian = le;
    end
  end

endmodule

@@ design/ac3_dts_header_classifier.sv @@
// ----------------------------------------------------------------------------
// ac3_dts_header_classifier
// AC-3 / E-AC-3 / DTS sync header classifier, one window per beat.
// ----------------------------------------------------------------------------
// Each input beat carries a ten-byte window taken at a candidate stream
// position and yields exactly one result beat saying whether the window
// starts an acceptable AC-3, E-AC-3 or DTS frame header; AC-3 / E-AC-3 wins
// over DTS. A new window is taken every cycle unless the output stalls;
// a window passes through one input register and one result register, and
// a stall on the output backs up through both registers. No CRC check
// is done. A rejected window returns all fields zero.
module ac3_dts_header_classifier import adhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // byte0[7:0] .. byte9[79:72]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // frame_bytes[14:0], sample_rate[32:15],
                                     // repeat_count[35:33], zero[39:36]
  output logic [4:0]  m_axis_tuser   // valid_res[0], stream_kind[3:1],
                                     // little_endian[4]
);

  logic     in_valid_q, in_valid_d;
  logic     out_valid_q, out_valid_d;
  window_t  win_q;
  hdr_res_t res_q, res_d;
  hdr_res_t ac3_res;
  hdr_res_t dts_res;
  logic     in_ready;
  logic     out_ready;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign in_ready  = !in_valid_q || out_ready;

  assign in_valid_d  = in_ready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) begin
      win_q <= s_axis_tdata;
    end
    if (in_valid_q && out_ready) begin
      res_q <= res_d;
    end
  end

  adhc_ac3_parse u_ac3 (
    .win_i (win_q),
    .res_o (ac3_res)
  );

  adhc_dts_parse u_dts (
    .win_i (win_q),
    .res_o (dts_res)
  );

  always_comb begin
    priority if (ac3_res.valid) res_d = ac3_res;
    else if (dts_res.valid)     res_d = dts_res;
    else                        res_d = '0;
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.repeat_count, res_q.sample_rate,
                          res_q.frame_bytes};
  assign m_axis_tuser  = {res_q.little_endian, res_q.kind, res_q.valid};

endmodule

@@ design/adhc_checker.sv @@
// ----------------------------------------------------------------------------
// adhc_checker
// Port-level checks for the header classifier, bound to the top level.
// ----------------------------------------------------------------------------
module adhc_checker import adhc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [79:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser
);

  logic [2:0] kind;
  logic [2:0] rpt;
  logic       in_beat;

  assign kind    = m_axis_tuser[3:1];
  assign rpt     = m_axis_tdata[35:33];
  assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0);

  // rejected window: every field zero
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0) && (kind == KIND_NONE) &&
      !m_axis_tuser[4])
    else $error("rejected result carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  a_ac3_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((kind == KIND_AC3) || (kind == KIND_EAC3))) |->
      (m_axis_tuser[0] && !m_axis_tuser[4]))
    else $error("AC-3 family result flagged little endian or invalid");

  a_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      ((kind == KIND_EAC3) ? ((rpt == 3'd1) || (rpt == 3'd2) || (rpt == 3'd3) ||
                              (rpt == 3'd6))
                           : (rpt == 3'd1)))
    else $error("repeat count does not match stream kind");

  // a nonzero window accepted into an empty, unstalled block shows up after the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !m_axis_tvalid && m_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted window produced no result");

endmodule

bind ac3_dts_header_classifier adhc_checker u_adhc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
